// ----- design/ccbi_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and helpers for the command byte interpreter.
package ccbi_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_program;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  character;
    logic [15:0] sleep_ticks;
    logic [1:0]  finish_status;
    logic        last_of_run;
  } out_t;

  // Interpreter phase between bytes
  typedef enum logic [1:0] {
    PH_OPCODE  = 2'd0,
    PH_OPERAND = 2'd1,
    PH_STRING  = 2'd2,
    PH_IGNORE  = 2'd3
  } phase_t;

  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_SLEEP  = 2'd1;
  localparam logic [1:0] KIND_YIELD  = 2'd2;
  localparam logic [1:0] KIND_FINISH = 2'd3;

  localparam logic [1:0] ST_END     = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_STREAM  = 2'd2;
  localparam logic [1:0] ST_TRUNC   = 2'd3;

  localparam logic [7:0] OP_STRING = 8'h01;
  localparam logic [7:0] OP_SLEEP  = 8'h02;
  localparam logic [7:0] OP_YIELD  = 8'h03;
  localparam logic [7:0] OP_DEC    = 8'h04;
  localparam logic [7:0] OP_HEX    = 8'h05;
  localparam logic [7:0] OP_END    = 8'hFF;

  localparam logic [3:0] DEC_BASE = 4'd10;
  // floor(n / 10) == (n * DEC_RECIP) >> 35 for every 32-bit n
  localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;

  localparam int DIGIT_DEPTH = 10;
  localparam int DIGIT_AW    = $clog2(DIGIT_DEPTH);

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_A    = 8'h61;

  // Divider handoff back to the sequencer
  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [3:0]  remainder;
  } div_result_t;

  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    if (d < 4'd10) g = CHAR_ZERO + {4'd0, d};
    else           g = CHAR_A + {4'd0, d} - 8'd10;
    return g;
  endfunction

endpackage

// ----- design/ccbi_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module ccbi_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/ccbi_divider.sv -----
`timescale 1ns / 1ps
// Digit extractor for base 10 or 16: base 10 by reciprocal multiply on one shared 32x16 multiplier, base 16 by shift.
module ccbi_divider (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     hex,
  input  logic [31:0]              dividend,
  output ccbi_pkg::div_result_t    result
);

  logic        running;
  logic [1:0]  step;
  logic        hex_mode;
  logic [31:0] num;
  logic [63:0] acc;
  logic [31:0] quo;
  logic [3:0]  rem;
  logic        done;
  logic [15:0] mul_b;
  logic [47:0] prod;
  logic [31:0] dec_quo;
  logic [31:0] dec_tens;
  logic [31:0] dec_rem;

  // low half of the reciprocal on the first pass, high half on the second
  assign mul_b    = (step == 2'd0) ? ccbi_pkg::DEC_RECIP[15:0] : ccbi_pkg::DEC_RECIP[31:16];
  assign prod     = {16'd0, num} * {32'd0, mul_b};
  assign dec_quo  = {3'd0, acc[63:35]};
  assign dec_tens = {dec_quo[28:0], 3'b000} + {dec_quo[30:0], 1'b0};
  assign dec_rem  = num - dec_tens;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        step     <= '0;
        num      <= dividend;
        hex_mode <= hex;
      end else if (running) begin
        step <= step + 2'd1;
        case (step)
          2'd0: begin
            if (hex_mode) begin
              quo     <= {4'd0, num[31:4]};
              rem     <= num[3:0];
              running <= 1'b0;
              done    <= 1'b1;
            end else begin
              acc <= {16'd0, prod};
            end
          end
          2'd1: acc <= acc + {prod, 16'd0};
          default: begin
            quo     <= dec_quo;
            rem     <= dec_rem[3:0];
            running <= 1'b0;
            done    <= 1'b1;
          end
        endcase
      end
    end
  end

  assign result.done      = done;
  assign result.quotient  = quo;
  assign result.remainder = rem;

  // done only ever follows a run that has just finished
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> !running) else $error("divider done while still running");
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    running && !start && step == 2'd2 |=> done) else $error("divider missed done");
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    done && !hex_mode |-> rem < ccbi_pkg::DEC_BASE) else $error("remainder out of range");

endmodule

// ----- design/console_command_byte_interpreter_top.sv -----
`timescale 1ns / 1ps
// Top level: byte decoder, result sequencer and number-to-digit conversion.
//
//  channel | direction | payload           | handshake
//  in      | input     | ccbi_pkg::in_t    | in_valid / in_stall
//  out     | output    | ccbi_pkg::out_t   | out_valid / out_stall
//
// A byte with no result passes through accept and decode only; each result it
// causes then adds an output state. A number print runs the shared divider once
// per digit (up to 10 digits), then reads each digit back via S_RD and S_OUT.
// Synchronous active-high reset returns the block to awaiting an opcode.
// in_stall is high from acceptance until the byte's last result is loaded into
// the output register; out_stall holds that register and pauses the sequencer.
module console_command_byte_interpreter_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ccbi_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ccbi_pkg::out_t   out_data
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_MAIN   = 7'b0000100,
    S_DIV    = 7'b0001000,
    S_RD     = 7'b0010000,
    S_OUT    = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  localparam int AW = ccbi_pkg::DIGIT_AW;

  state_t state, state_next;

  // interpreter state
  ccbi_pkg::phase_t phase, phase_next;
  logic [2:0]  pend_op, pend_op_next;
  logic [2:0]  seen, seen_next;
  logic [31:0] val, val_next;
  logic [15:0] sbl, sbl_next;

  // latched input byte
  logic [7:0] in_b;
  logic       in_eop;

  // pending results of the current byte
  logic        main_vld_next;
  logic [1:0]  main_kind, main_kind_next;
  logic [7:0]  main_char, main_char_next;
  logic [15:0] main_ticks, main_ticks_next;
  logic        num_vld_next;
  logic        num_hex;
  logic        fin_vld, fin_vld_next;
  logic [1:0]  fin_status, fin_status_next;

  logic [AW-1:0] cnt;
  logic [AW-1:0] idx;

  logic                  div_start;
  logic [31:0]           div_dividend;
  ccbi_pkg::div_result_t div_res;

  logic          ram_wr;
  logic          ram_rd;
  logic [3:0]    ram_rdata;

  logic           out_free;
  logic           out_load;
  ccbi_pkg::out_t out_value;

  logic in_accept;
  assign in_accept = in_valid && !in_stall;
  assign in_stall  = state != S_IDLE;
  assign out_free  = !out_valid || !out_stall;

  // ---------------- byte decode ----------------
  always_comb begin
    logic [2:0]  need;
    logic [31:0] merged;
    logic [15:0] sbl_dec;
    phase_next      = phase;
    pend_op_next    = pend_op;
    seen_next       = seen;
    val_next        = val;
    sbl_next        = sbl;
    main_vld_next   = 1'b0;
    main_kind_next  = ccbi_pkg::KIND_CHAR;
    main_char_next  = '0;
    main_ticks_next = '0;
    num_vld_next    = 1'b0;
    fin_vld_next    = 1'b0;
    fin_status_next = ccbi_pkg::ST_END;
    need    = (pend_op == ccbi_pkg::OP_DEC[2:0] || pend_op == ccbi_pkg::OP_HEX[2:0])
              ? 3'd4 : 3'd2;
    merged  = val;
    sbl_dec = (sbl != 16'd0) ? sbl - 16'd1 : sbl;
    case (seen[1:0])
      2'd0:    merged[7:0]   = val[7:0]   | in_b;
      2'd1:    merged[15:8]  = val[15:8]  | in_b;
      2'd2:    merged[23:16] = val[23:16] | in_b;
      default: merged[31:24] = val[31:24] | in_b;
    endcase
    case (phase)
      ccbi_pkg::PH_OPCODE: begin
        if (in_b == ccbi_pkg::OP_STRING || in_b == ccbi_pkg::OP_SLEEP ||
            in_b == ccbi_pkg::OP_DEC || in_b == ccbi_pkg::OP_HEX) begin
          pend_op_next = in_b[2:0];
          seen_next    = '0;
          val_next     = '0;
          phase_next   = ccbi_pkg::PH_OPERAND;
          if (in_eop) begin
            fin_vld_next    = 1'b1;
            fin_status_next = ccbi_pkg::ST_TRUNC;
            phase_next      = ccbi_pkg::PH_OPCODE;
          end
        end else if (in_b == ccbi_pkg::OP_YIELD) begin
          main_vld_next  = 1'b1;
          main_kind_next = ccbi_pkg::KIND_YIELD;
          if (in_eop) begin
            fin_vld_next    = 1'b1;
            fin_status_next = ccbi_pkg::ST_STREAM;
          end
        end else begin
          fin_vld_next    = 1'b1;
          fin_status_next = (in_b == ccbi_pkg::OP_END) ? ccbi_pkg::ST_END
                                                       : ccbi_pkg::ST_UNKNOWN;
          phase_next      = in_eop ? ccbi_pkg::PH_OPCODE : ccbi_pkg::PH_IGNORE;
        end
      end
      ccbi_pkg::PH_OPERAND: begin
        val_next  = merged;
        seen_next = seen + 3'd1;
        if (seen + 3'd1 >= need) begin
          phase_next = ccbi_pkg::PH_OPCODE;
          if (pend_op == ccbi_pkg::OP_STRING[2:0]) begin
            sbl_next = merged[15:0];
            if (merged[15:0] != 16'd0) phase_next = ccbi_pkg::PH_STRING;
          end else if (pend_op == ccbi_pkg::OP_SLEEP[2:0]) begin
            main_vld_next   = 1'b1;
            main_kind_next  = ccbi_pkg::KIND_SLEEP;
            main_ticks_next = merged[15:0];
          end else if (merged == 32'd0) begin
            main_vld_next  = 1'b1;
            main_kind_next = ccbi_pkg::KIND_CHAR;
            main_char_next = ccbi_pkg::CHAR_ZERO;
          end else begin
            num_vld_next = 1'b1;
          end
          if (in_eop) begin
            fin_vld_next    = 1'b1;
            fin_status_next = ccbi_pkg::ST_STREAM;
            phase_next      = ccbi_pkg::PH_OPCODE;
          end
        end else if (in_eop) begin
          fin_vld_next    = 1'b1;
          fin_status_next = ccbi_pkg::ST_TRUNC;
          phase_next      = ccbi_pkg::PH_OPCODE;
        end
      end
      ccbi_pkg::PH_STRING: begin
        main_vld_next  = 1'b1;
        main_kind_next = ccbi_pkg::KIND_CHAR;
        main_char_next = in_b;
        sbl_next       = sbl_dec;
        if (sbl_dec == 16'd0) phase_next = ccbi_pkg::PH_OPCODE;
        if (in_eop) begin
          fin_vld_next    = 1'b1;
          fin_status_next = ccbi_pkg::ST_STREAM;
          phase_next      = ccbi_pkg::PH_OPCODE;
        end
      end
      default: begin
        if (in_eop) phase_next = ccbi_pkg::PH_OPCODE;
      end
    endcase
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_accept) state_next = S_DECODE;
      S_DECODE: begin
        if (main_vld_next)     state_next = S_MAIN;
        else if (num_vld_next) state_next = S_DIV;
        else if (fin_vld_next) state_next = S_FIN;
        else                   state_next = S_IDLE;
      end
      S_MAIN:   if (out_free) state_next = fin_vld ? S_FIN : S_IDLE;
      S_DIV: begin
        if (div_res.done && div_res.quotient == 32'd0) state_next = S_RD;
      end
      S_RD:     state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          if (idx != '0)    state_next = S_RD;
          else if (fin_vld) state_next = S_FIN;
          else              state_next = S_IDLE;
        end
      end
      S_FIN:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign div_start    = (state == S_DECODE && num_vld_next) ||
                        (state == S_DIV && div_res.done && div_res.quotient != 32'd0);
  assign div_dividend = (state == S_DECODE) ? val_next : div_res.quotient;
  assign ram_wr       = state == S_DIV && div_res.done;
  assign ram_rd       = state == S_RD;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      phase   <= ccbi_pkg::PH_OPCODE;
      pend_op <= '0;
      seen    <= '0;
      val     <= '0;
      sbl     <= '0;
      fin_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DECODE) begin
        phase      <= phase_next;
        pend_op    <= pend_op_next;
        seen       <= seen_next;
        val        <= val_next;
        sbl        <= sbl_next;
        fin_vld    <= fin_vld_next;
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_b   <= in_data.data_byte;
      in_eop <= in_data.end_of_program;
    end
    if (state == S_DECODE) begin
      main_kind  <= main_kind_next;
      main_char  <= main_char_next;
      main_ticks <= main_ticks_next;
      fin_status <= fin_status_next;
      num_hex    <= pend_op == ccbi_pkg::OP_HEX[2:0];
      cnt        <= '0;
    end
    if (ram_wr) begin
      if (div_res.quotient != 32'd0) cnt <= cnt + AW'(1);
      else                           idx <= cnt;
    end
    if (state == S_OUT && out_free && idx != '0) idx <= idx - AW'(1);
  end

  ccbi_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .hex      ((state == S_DECODE) ? (pend_op == ccbi_pkg::OP_HEX[2:0]) : num_hex),
    .dividend (div_dividend),
    .result   (div_res)
  );

  ccbi_ram #(
    .WIDTH (4),
    .DEPTH (ccbi_pkg::DIGIT_DEPTH)
  ) u_digits (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (cnt),
    .wr_data (div_res.remainder),
    .rd_en   (ram_rd),
    .rd_addr (idx),
    .rd_data (ram_rdata)
  );

  // ---------------- output register ----------------
  always_comb begin
    out_value = '0;
    out_load  = 1'b0;
    case (state)
      S_MAIN: begin
        out_load              = out_free;
        out_value.kind        = main_kind;
        out_value.character   = main_char;
        out_value.sleep_ticks = main_ticks;
        out_value.last_of_run = !fin_vld;
      end
      S_OUT: begin
        out_load              = out_free;
        out_value.kind        = ccbi_pkg::KIND_CHAR;
        out_value.character   = ccbi_pkg::glyph(ram_rdata);
        out_value.last_of_run = idx == '0 && !fin_vld;
      end
      S_FIN: begin
        out_load                = out_free;
        out_value.kind          = ccbi_pkg::KIND_FINISH;
        out_value.finish_status = fin_status;
        out_value.last_of_run   = 1'b1;
      end
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= out_value;
  end

  a_string_len: assert property (@(posedge clk) disable iff (rst)
    phase == ccbi_pkg::PH_STRING |-> sbl != 16'd0)
    else $error("string phase with no bytes left");
  a_operand_cnt: assert property (@(posedge clk) disable iff (rst)
    phase == ccbi_pkg::PH_OPERAND |-> seen < 3'd4)
    else $error("operand count overrun");
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == S_DECODE)
    else $error("accepted byte not decoded");
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == S_DIV)
    else $error("divider result outside conversion");
  a_digit_idx: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |-> idx < AW'(ccbi_pkg::DIGIT_DEPTH))
    else $error("digit index out of range");

endmodule
